// ----- hw/rtl/rgcd_pkg.sv -----
// Shared types and constants of the RSSI gate crossing detector.
package rgcd_pkg;

  localparam int SLOTS    = 4;
  localparam int ADDR_W   = 48;
  localparam int LVL_W    = 8;
  localparam int AVG_W    = 16;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 32;
  localparam int CD_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int IDX_W    = 2;

  localparam int EMA_NEW_WT = 77;
  localparam int EMA_OLD_WT = 179;

  localparam logic signed [LVL_W-1:0] RESET_LEVEL = -8'sd120;
  localparam logic signed [AVG_W-1:0] RESET_AVG   = -16'sd30720;
  localparam logic [THR_W-1:0]        ENTER_RESET = 32'hB0B0_B0B0;
  localparam logic [THR_W-1:0]        EXIT_RESET  = 32'hA6A6_A6A6;
  localparam logic [CD_W-1:0]         COOLDOWN_RESET = 16'd3000;

  typedef enum logic [1:0] {
    FUNC_PACKET = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_START  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PILOT0   = 3'd0,
    CFG_PILOT1   = 3'd1,
    CFG_PILOT2   = 3'd2,
    CFG_PILOT3   = 3'd3,
    CFG_ENABLE   = 3'd4,
    CFG_ENTER    = 3'd5,
    CFG_EXIT     = 3'd6,
    CFG_COOLDOWN = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_CALC   = 2'd1,
    S_UPDATE = 2'd2,
    S_FLUSH  = 2'd3
  } seq_state_t;

endpackage

// ----- hw/rtl/rgcd_if.sv -----
// Valid/ready channel interfaces for the detector's input and result items.
interface rgcd_in_if import rgcd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic [ADDR_W-1:0]        source_address;
  logic signed [LVL_W-1:0]  signal_strength;
  logic [TIME_W-1:0]        time_ms;

  modport source (output valid, func, source_address, signal_strength, time_ms,
                  input ready);
  modport sink (input valid, func, source_address, signal_strength, time_ms,
                output ready);
endinterface

interface rgcd_out_if import rgcd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         pilot_index;
  logic signed [LVL_W-1:0]  peak_level;
  logic [TIME_W-1:0]        peak_time;
  logic                     last_lap;

  modport source (output valid, pilot_index, peak_level, peak_time, last_lap,
                  input ready);
  modport sink (input valid, pilot_index, peak_level, peak_time, last_lap,
                output ready);
endinterface

// ----- hw/rtl/rssi_gate_crossing_detector.sv -----
// Top level: pilot matching, per-slot smoothing, hysteresis and lap reporting.
//
//   channel | dir | handshake     | payload
//   in_ch   | in  | valid/ready   | func, source_address, signal_strength, time_ms
//   out_ch  | out | valid/ready   | pilot_index, peak_level, peak_time, last_lap
//   cfg_*   | in  | cfg_we        | cfg_index, cfg_data
//
// Packet, race-start and unused items leave the sequencer idle and in_ch ready.
// A tick walks the slots one at a time through the single shared average unit:
// S_CALC for every slot, S_UPDATE for each enabled slot, then S_FLUSH.
// Reset is synchronous; no clearing pass is needed.
// A lap waits in a hold register until the next lap or the end of the tick moves
// it on; moving it while out_ch has not taken the previous item stalls the tick.
module rssi_gate_crossing_detector import rgcd_pkg::*; #(
  parameter int NUM_PILOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rgcd_in_if.sink               in_ch,
  rgcd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = (NUM_PILOTS > 1) ? $clog2(NUM_PILOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_PILOTS - 1);

  // configuration
  logic [SLOTS-1:0][ADDR_W-1:0] addr_r;
  logic [SLOTS-1:0]             mask_r;
  logic [SLOTS-1:0][LVL_W-1:0]  enter_r;
  logic [SLOTS-1:0][LVL_W-1:0]  exit_r;
  logic [CD_W-1:0]              cooldown_r;

  // per-slot state
  logic signed [LVL_W-1:0]  raw_r      [NUM_PILOTS];
  logic signed [AVG_W-1:0]  smooth_r   [NUM_PILOTS];
  logic                     cross_r    [NUM_PILOTS];
  logic signed [LVL_W-1:0]  peak_r     [NUM_PILOTS];
  logic [TIME_W-1:0]        pstamp_r   [NUM_PILOTS];
  logic [TIME_W-1:0]        lstamp_r   [NUM_PILOTS];

  // sequencer
  seq_state_t               state_r, state_nxt;
  logic [SW-1:0]            slot_r, slot_nxt;
  logic [TIME_W-1:0]        now_r;
  logic signed [AVG_W-1:0]  avg_r;
  logic signed [AVG_W-1:0]  avg_new;

  // held lap and output register
  logic                     hold_v_r;
  logic [IDX_W-1:0]         hold_idx_r;
  logic signed [LVL_W-1:0]  hold_peak_r;
  logic [TIME_W-1:0]        hold_time_r;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic signed [LVL_W-1:0]  out_peak_r;
  logic [TIME_W-1:0]        out_time_r;
  logic                     out_last_r;

  logic in_fire, out_free;
  logic calc_en, upd_en, push_en, push_last, hold_load, hold_clr;
  logic slot_en, slot_last;

  logic                     hit;
  logic [SW-1:0]            hit_idx;

  logic signed [LVL_W-1:0]  whole;
  logic signed [AVG_W-1:0]  enter_q, exit_q;
  logic signed [LVL_W-1:0]  pk_nxt;
  logic [TIME_W-1:0]        pst_nxt;
  logic                     enter_hit, exit_hit, cd_ok, lap;
  logic [TIME_W-1:0]        elapsed;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pilot_index = out_idx_r;
  assign out_ch.peak_level  = out_peak_r;
  assign out_ch.peak_time   = out_time_r;
  assign out_ch.last_lap    = out_last_r;

  assign slot_en   = mask_r[slot_r];
  assign slot_last = (slot_r == LAST_SLOT);

  rgcd_ema u_ema (
    .raw (raw_r[slot_r]),
    .old (smooth_r[slot_r]),
    .avg (avg_new)
  );

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_PILOTS - 1; i >= 0; i--) begin
      if (mask_r[i] && (addr_r[i] == in_ch.source_address)) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
    end
  end

  // hysteresis and peak tracking on the registered average
  always_comb begin
    whole     = avg_r[AVG_W-1:8] + LVL_W'(avg_r[AVG_W-1] && (avg_r[7:0] != 8'd0));
    enter_q   = {enter_r[slot_r], 8'd0};
    exit_q    = {exit_r[slot_r], 8'd0};
    enter_hit = (avg_r > enter_q);
    exit_hit  = (avg_r < exit_q);
    elapsed   = now_r - lstamp_r[slot_r];
    cd_ok     = (elapsed >= TIME_W'(cooldown_r));
    if (whole > peak_r[slot_r]) begin
      pk_nxt  = whole;
      pst_nxt = now_r;
    end else begin
      pk_nxt  = peak_r[slot_r];
      pst_nxt = pstamp_r[slot_r];
    end
    lap = cross_r[slot_r] && exit_hit && cd_ok;
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    calc_en   = 1'b0;
    upd_en    = 1'b0;
    push_en   = 1'b0;
    push_last = 1'b0;
    hold_load = 1'b0;
    hold_clr  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (func_t'(in_ch.func) == FUNC_TICK)) begin
          state_nxt = S_CALC;
          slot_nxt  = '0;
        end
      end
      S_CALC: begin
        if (slot_en) begin
          calc_en   = 1'b1;
          state_nxt = S_UPDATE;
        end else if (slot_last) begin
          state_nxt = S_FLUSH;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_UPDATE: begin
        if (!(lap && hold_v_r && !out_free)) begin
          upd_en = 1'b1;
          if (lap) begin
            hold_load = 1'b1;
            push_en   = hold_v_r;
          end
          if (slot_last) begin
            state_nxt = S_FLUSH;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = S_CALC;
          end
        end
      end
      S_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push_en   = 1'b1;
          push_last = 1'b1;
          hold_clr  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= '0;
      mask_r     <= '0;
      enter_r    <= ENTER_RESET;
      exit_r     <= EXIT_RESET;
      cooldown_r <= COOLDOWN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PILOT0:   addr_r[0]  <= cfg_data[ADDR_W-1:0];
        CFG_PILOT1:   addr_r[1]  <= cfg_data[ADDR_W-1:0];
        CFG_PILOT2:   addr_r[2]  <= cfg_data[ADDR_W-1:0];
        CFG_PILOT3:   addr_r[3]  <= cfg_data[ADDR_W-1:0];
        CFG_ENABLE:   mask_r     <= cfg_data[SLOTS-1:0];
        CFG_ENTER:    enter_r    <= cfg_data[THR_W-1:0];
        CFG_EXIT:     exit_r     <= cfg_data[THR_W-1:0];
        CFG_COOLDOWN: cooldown_r <= cfg_data[CD_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && (func_t'(in_ch.func) == FUNC_START))) begin
      for (int i = 0; i < NUM_PILOTS; i++) begin
        raw_r[i]    <= RESET_LEVEL;
        smooth_r[i] <= RESET_AVG;
        cross_r[i]  <= 1'b0;
        peak_r[i]   <= RESET_LEVEL;
        pstamp_r[i] <= '0;
        lstamp_r[i] <= '0;
      end
    end else begin
      if (in_fire && (func_t'(in_ch.func) == FUNC_PACKET) && hit) begin
        raw_r[hit_idx] <= in_ch.signal_strength;
      end
      if (calc_en) begin
        smooth_r[slot_r] <= avg_new;
      end
      if (upd_en) begin
        if (!cross_r[slot_r]) begin
          if (enter_hit) begin
            cross_r[slot_r]  <= 1'b1;
            peak_r[slot_r]   <= whole;
            pstamp_r[slot_r] <= now_r;
          end
        end else begin
          peak_r[slot_r]   <= pk_nxt;
          pstamp_r[slot_r] <= pst_nxt;
          if (exit_hit) begin
            cross_r[slot_r] <= 1'b0;
            if (cd_ok) begin
              lstamp_r[slot_r] <= now_r;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_r <= in_ch.time_ms;
    end
    if (calc_en) begin
      avg_r <= avg_new;
    end
    if (hold_load) begin
      hold_idx_r  <= IDX_W'(slot_r);
      hold_peak_r <= pk_nxt;
      hold_time_r <= pst_nxt;
    end
    if (push_en) begin
      out_idx_r  <= hold_idx_r;
      out_peak_r <= hold_peak_r;
      out_time_r <= hold_time_r;
      out_last_r <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (hold_load) begin
        hold_v_r <= 1'b1;
      end else if (hold_clr) begin
        hold_v_r <= 1'b0;
      end
      if (push_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_v_r)
    else $error("held lap left behind after tick");

  a_tick_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.func == FUNC_TICK)) |=> (state_r == S_CALC) && (slot_r == '0))
    else $error("tick did not start slot walk");

  a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && hold_v_r && out_free) |=> out_valid_r && out_last_r)
    else $error("final lap of tick not marked last");

  a_update_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE && push_en) |=> out_valid_r && !out_last_r)
    else $error("intermediate lap marked last");

  a_no_push_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push_en |-> out_free)
    else $error("result register overwritten while waiting");

endmodule

// ----- hw/rtl/rgcd_ema.sv -----
// Shared exponential average unit: new = floor((77*raw*256 + 179*old) / 256).
module rgcd_ema import rgcd_pkg::*; (
  input  logic signed [LVL_W-1:0] raw,
  input  logic signed [AVG_W-1:0] old,
  output logic signed [AVG_W-1:0] avg
);

  localparam int SUM_W = 26;
  localparam logic signed [SUM_W-1:0] K_NEW = SUM_W'(EMA_NEW_WT);
  localparam logic signed [SUM_W-1:0] K_OLD = SUM_W'(EMA_OLD_WT);

  logic signed [SUM_W-1:0] raw_x;
  logic signed [SUM_W-1:0] old_x;
  logic signed [SUM_W-1:0] sum;

  assign raw_x = SUM_W'(raw);
  assign old_x = SUM_W'(old);
  assign sum   = ((raw_x * K_NEW) <<< 8) + (old_x * K_OLD);
  assign avg   = sum[AVG_W+7:8];

endmodule
